@@ design/arl_pkg.sv @@
// ----------------------------------------------------------------------------
// Address range lookup package
// Shared types and codes for the address range table and its cells.
// ----------------------------------------------------------------------------
package arl_pkg;

  // Default number of table entries (one cell per entry).
  localparam int TABLE_ENTRIES_DEF = 16;

  // Operation codes carried in the opcode field.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_HIT       = 3'd3;
  localparam logic [2:0] ST_MISS      = 3'd4;

  // Input beat.
  typedef struct packed {
    logic        opcode;
    logic [63:0] addr;
    logic [63:0] range_limit;
    logic [15:0] region_tag;
  } arl_in_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hit_tag;
    logic [63:0] hit_start;
    logic [63:0] hit_end;
    logic [63:0] hit_offset;
  } arl_out_t;

  // Token that walks down the row of cells, gathering search results.
  typedef struct packed {
    logic        vld;
    arl_in_t     item;
    logic        dup;
    logic        free_found;
    logic        best_found;
    logic [63:0] best_start;
    logic [63:0] best_end;
    logic [15:0] best_tag;
  } arl_tok_t;

  // Entry write broadcast to all cells; the target index travels beside it.
  typedef struct packed {
    logic        en;
    logic [63:0] start;
    logic [63:0] limit;
    logic [15:0] tag;
  } arl_wr_t;

endpackage

@@ design/arl_cell.sv @@
// ----------------------------------------------------------------------------
// Address range table cell
// Holds one table entry and advances the search token by one position.
// ----------------------------------------------------------------------------
module arl_cell #(
  parameter int IDX_W         = 4,
  parameter int CELL_IDX      = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arl_pkg::arl_tok_t   tok_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  output arl_pkg::arl_tok_t   tok_o,
  output logic [IDX_W-1:0]    free_idx_o,
  input  arl_pkg::arl_wr_t    wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i
);
  import arl_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid_r;
  logic [63:0]      start_r;
  logic [63:0]      end_r;
  logic [15:0]      tag_r;
  arl_tok_t         tok_r;
  arl_tok_t         tok_nxt;
  logic [IDX_W-1:0] free_idx_r;
  logic [IDX_W-1:0] free_idx_nxt;
  logic             same_start;
  logic             better;

  // Compare the stored entry against the passing token.
  always_comb begin
    same_start   = valid_r && (start_r == tok_i.item.addr);
    better       = valid_r && (start_r <= tok_i.item.addr) &&
                   (!tok_i.best_found || (start_r > tok_i.best_start));
    tok_nxt      = tok_i;
    free_idx_nxt = free_idx_i;
    if (tok_i.item.opcode == OP_INSERT) begin
      if (same_start) begin
        tok_nxt.dup = 1'b1;
      end
      // The lowest free index wins, so only the first free cell claims it.
      if (!valid_r && !tok_i.free_found) begin
        tok_nxt.free_found = 1'b1;
        free_idx_nxt       = MY_IDX;
      end
    end else if (better) begin
      tok_nxt.best_found = 1'b1;
      tok_nxt.best_start = start_r;
      tok_nxt.best_end   = end_r;
      tok_nxt.best_tag   = tag_r;
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.item       <= tok_nxt.item;
    tok_r.dup        <= tok_nxt.dup;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.best_found <= tok_nxt.best_found;
    tok_r.best_start <= tok_nxt.best_start;
    tok_r.best_end   <= tok_nxt.best_end;
    tok_r.best_tag   <= tok_nxt.best_tag;
    free_idx_r       <= free_idx_nxt;
  end

  // Entry storage, written by the end of the row when an insert commits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_i.en && (wr_idx_i == MY_IDX)) begin
      valid_r <= 1'b1;
    end
    if (wr_i.en && (wr_idx_i == MY_IDX)) begin
      start_r <= wr_i.start;
      end_r   <= wr_i.limit;
      tag_r   <= wr_i.tag;
    end
  end

  assign tok_o      = tok_r;
  assign free_idx_o = free_idx_r;

endmodule

@@ design/address_range_table_lookup_unit.sv @@
// ----------------------------------------------------------------------------
// Address range table lookup unit
// Table of address ranges searched by a token that walks a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one beat per item:
//   an insert of a range (start, exclusive end, region tag) or a lookup of
//   an address. The result channel (out_valid/out_ready/out_data) returns
//   exactly one beat per item with a status and, on a lookup hit, the tag,
//   start, end and offset of the matching range.
//   Each table entry lives in its own cell. An accepted item becomes a token
//   that moves one cell per cycle down the row of TABLE_ENTRIES cells, and
//   the result is registered in the output register after the last cell.
//   One item is in flight at a time: in_ready drops at acceptance and rises
//   again in the cycle after the result beat is taken, so the length of the
//   cell row sets how long each item holds the unit.
//   An insert writes its entry at the end of the row, in the same cycle its
//   result is registered, so the next item always sees it.
//   Synchronous reset clears every entry's valid bit and the handshakes.
//   If the receiver stalls, the result stays on out_data and no new item
//   is accepted until it is taken.
// ----------------------------------------------------------------------------
module address_range_table_lookup_unit #(
  parameter int TABLE_ENTRIES = arl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arl_pkg::arl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output arl_pkg::arl_out_t out_data
);
  import arl_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  arl_tok_t         tok      [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] free_idx [TABLE_ENTRIES+1];
  arl_wr_t          wr;
  logic [IDX_W-1:0] wr_idx;
  logic             busy_r;
  logic             out_valid_r;
  arl_out_t         out_r;
  arl_out_t         res;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid_r && out_ready;

  // Fresh token for the head of the row.
  always_comb begin
    tok[0]            = '0;
    tok[0].vld        = in_acc;
    tok[0].item       = in_data;
    free_idx[0]       = '0;
  end

  // Row of cells, one per table entry.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    arl_cell #(
      .IDX_W         (IDX_W),
      .CELL_IDX      (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok[g]),
      .free_idx_i (free_idx[g]),
      .tok_o      (tok[g+1]),
      .free_idx_o (free_idx[g+1]),
      .wr_i       (wr),
      .wr_idx_i   (wr_idx)
    );
  end

  // Resolve the token leaving the last cell into a result and an entry write.
  always_comb begin
    res      = '0;
    wr       = '0;
    wr.start = tok[TABLE_ENTRIES].item.addr;
    wr.limit = tok[TABLE_ENTRIES].item.range_limit;
    wr.tag   = tok[TABLE_ENTRIES].item.region_tag;
    wr_idx   = free_idx[TABLE_ENTRIES];
    if (tok[TABLE_ENTRIES].item.opcode == OP_INSERT) begin
      if (tok[TABLE_ENTRIES].dup) begin
        res.status = ST_DUPLICATE;
      end else if (!tok[TABLE_ENTRIES].free_found) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_INSERTED;
        wr.en      = tok[TABLE_ENTRIES].vld;
      end
    end else if (tok[TABLE_ENTRIES].best_found &&
                 (tok[TABLE_ENTRIES].item.addr < tok[TABLE_ENTRIES].best_end)) begin
      res.status     = ST_HIT;
      res.hit_tag    = tok[TABLE_ENTRIES].best_tag;
      res.hit_start  = tok[TABLE_ENTRIES].best_start;
      res.hit_end    = tok[TABLE_ENTRIES].best_end;
      res.hit_offset = tok[TABLE_ENTRIES].item.addr - tok[TABLE_ENTRIES].best_start;
    end else begin
      res.status = ST_MISS;
    end
  end

  // Output register and the busy flag that admits one item at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (out_acc) begin
        busy_r <= 1'b0;
      end
      if (tok[TABLE_ENTRIES].vld) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
    if (tok[TABLE_ENTRIES].vld) begin
      out_r <= res;
    end
  end

  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/arl_checker.sv @@
// ----------------------------------------------------------------------------
// Address range lookup port checker
// Port-level assertions for the address range table lookup unit.
// ----------------------------------------------------------------------------
module arl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input arl_pkg::arl_out_t out_data
);
  import arl_pkg::*;

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Only one item is in flight: acceptance closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  // No new item is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input open while a result is pending");

  // Non-hit results carry zeroed hit fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_HIT) |->
      (out_data.hit_tag == '0) && (out_data.hit_start == '0) &&
      (out_data.hit_end == '0) && (out_data.hit_offset == '0))
    else $error("hit fields set on a non-hit result");

  // A hit's offset and start stay inside the reported range.
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_HIT) |->
      (out_data.hit_start < out_data.hit_end) &&
      (out_data.hit_offset < (out_data.hit_end - out_data.hit_start)))
    else $error("hit outside its range");

endmodule

bind address_range_table_lookup_unit arl_checker u_arl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// Address range table lookup unit testbench
// Runs directed and random inserts and lookups through the range table. Each
// accepted beat is resolved against a local copy of the table. Every result
// beat is compared field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import arl_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  arl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  arl_out_t out_data;

  // Local copy of the range table.
  logic        tbl_valid [ENTRIES];
  logic [63:0] tbl_start [ENTRIES];
  logic [63:0] tbl_end   [ENTRIES];
  logic [15:0] tbl_tag   [ENTRIES];

  arl_out_t range_results_pending [$];
  int       mismatch_count = 0;
  bit       no_idle = 1'b0;

  address_range_table_lookup_unit #(
    .TABLE_ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int used_entries();
    int cnt;
    cnt = 0;
    foreach (tbl_valid[i]) cnt += tbl_valid[i];
    return cnt;
  endfunction

  // Applies one item to the local table and returns the beat it should cause.
  function automatic arl_out_t resolve_range_item(input arl_in_t item);
    arl_out_t res;
    int       free_slot;
    int       best;
    logic     dup;
    res = '0;
    free_slot = -1;
    best = -1;
    dup = 1'b0;
    if (item.opcode == OP_INSERT) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (tbl_start[i] == item.addr) dup = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      // A matching start wins over a full table.
      if (dup) begin
        res.status = ST_DUPLICATE;
      end else if (free_slot < 0) begin
        res.status = ST_FULL;
      end else begin
        tbl_valid[free_slot] = 1'b1;
        tbl_start[free_slot] = item.addr;
        tbl_end[free_slot]   = item.range_limit;
        tbl_tag[free_slot]   = item.region_tag;
        res.status = ST_INSERTED;
      end
    end else begin
      // Greatest start at or below the address; empty ranges still shadow.
      for (int i = 0; i < ENTRIES; i++) begin
        if (tbl_valid[i] && tbl_start[i] <= item.addr) begin
          if (best < 0 || tbl_start[i] > tbl_start[best]) best = i;
        end
      end
      if (best >= 0 && item.addr < tbl_end[best]) begin
        res.status     = ST_HIT;
        res.hit_tag    = tbl_tag[best];
        res.hit_start  = tbl_start[best];
        res.hit_end    = tbl_end[best];
        res.hit_offset = item.addr - tbl_start[best];
      end else begin
        res.status = ST_MISS;
      end
    end
    return res;
  endfunction

  function automatic arl_in_t make_insert(input logic [63:0] start, input logic [63:0] limit,
                                          input logic [15:0] tag);
    arl_in_t item;
    item.opcode      = OP_INSERT;
    item.addr        = start;
    item.range_limit = limit;
    item.region_tag  = tag;
    return item;
  endfunction

  // The limit and tag of a lookup are ignored, so they carry random noise.
  function automatic arl_in_t make_lookup(input logic [63:0] address);
    arl_in_t item;
    item.opcode      = OP_LOOKUP;
    item.addr        = address;
    item.range_limit = rand64();
    item.region_tag  = 16'($urandom);
    return item;
  endfunction

  // Sends one beat after a random gap and records its predicted result.
  task automatic send_item(input arl_in_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    range_results_pending.push_back(resolve_range_item(item));
  endtask

  // Lookups on an empty table miss at both ends of the address space.
  task automatic test_empty_table();
    send_item(make_lookup(64'h0));
    send_item(make_lookup(~64'h0));
  endtask

  // A plain range, a refused duplicate start, hits inside it and a miss at its exclusive end.
  task automatic test_insert_duplicate();
    send_item(make_insert(64'h0, 64'h1000, 16'hFFFF));
    send_item(make_insert(64'h0, 64'h5000, 16'h0000));
    send_item(make_lookup(64'h0));
    send_item(make_lookup(64'hFFF));
    send_item(make_lookup(64'h1000));
  endtask

  // Empty and inverted ranges never hit but hide lower ranges above their start.
  task automatic test_shadowing();
    send_item(make_insert(64'h800, 64'h800, 16'h1234));
    send_item(make_lookup(64'h900));
    send_item(make_lookup(64'h7FF));
    send_item(make_insert(64'h2000, 64'h1800, 16'h5A5A));
    send_item(make_lookup(64'h2000));
    send_item(make_lookup(64'h1FFF));
  endtask

  // Ranges at the top of the address space and a huge offset.
  task automatic test_address_extremes();
    send_item(make_insert(64'hFFFF_FFFF_FFFF_FFF0, ~64'h0, 16'h8001));
    send_item(make_lookup(~64'h0));
    send_item(make_lookup(64'hFFFF_FFFF_FFFF_FFFE));
    send_item(make_insert(64'h8000_0000_0000_0000, ~64'h0, 16'h7FFE));
    send_item(make_lookup(64'hFFFF_FFFF_FFFF_FFEF));
    send_item(make_lookup(64'h7FFF_FFFF_FFFF_FFFF));
  endtask

  // Random inserts fill the table; half of the lookups aim at entry edges.
  task automatic test_random_traffic(input int count);
    int          n;
    int          used;
    int          k;
    logic [63:0] a;
    logic [63:0] e;
    for (n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      used = used_entries();
      k = (used > 0) ? $urandom_range(0, used - 1) : 0;
      if ($urandom_range(0, 99) < 20) begin
        // Once the table is full, half of the inserts repeat a known start.
        if (used > 0 && $urandom_range(0, 9) < ((used == ENTRIES) ? 5 : 1)) begin
          a = tbl_start[k];
        end else begin
          case ($urandom_range(0, 3))
            0: a = rand64();
            1: a = tbl_start[k] + $urandom_range(1, 256);
            2: a = 64'($urandom_range(0, 65535));
            default: a = ~64'h0 - $urandom_range(0, 65535);
          endcase
        end
        case ($urandom_range(0, 3))
          0: e = a;
          1: e = a + $urandom_range(1, 4096);
          2: e = a + (rand64() >> $urandom_range(0, 63));
          default: e = rand64();
        endcase
        send_item(make_insert(a, e, 16'($urandom)));
      end else begin
        case ($urandom_range(0, 7))
          0: a = tbl_start[k];
          1: a = tbl_start[k] - 1;
          2: a = tbl_end[k] - 1;
          3: a = tbl_end[k];
          4: begin
            if (tbl_end[k] > tbl_start[k])
              a = tbl_start[k] + rand64() % (tbl_end[k] - tbl_start[k]);
            else
              a = tbl_start[k];
          end
          5: a = rand64();
          6: a = 64'($urandom_range(0, 65535));
          default: a = ~64'h0 - $urandom_range(0, 65535);
        endcase
        send_item(make_lookup(a));
      end
    end
  endtask

  // Result side: random stalls, then each beat is checked against the oldest prediction.
  initial begin
    int       stall;
    arl_out_t want;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (range_results_pending.size() == 0) begin
        $error("result beat with no prediction waiting: %h", out_data);
        mismatch_count++;
      end else begin
        want = range_results_pending.pop_front();
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.hit_tag !== want.hit_tag) begin
          $error("hit_tag mismatch: expected %h, actual %h", want.hit_tag, out_data.hit_tag);
          mismatch_count++;
        end
        if (out_data.hit_start !== want.hit_start) begin
          $error("hit_start mismatch: expected %h, actual %h",
                 want.hit_start, out_data.hit_start);
          mismatch_count++;
        end
        if (out_data.hit_end !== want.hit_end) begin
          $error("hit_end mismatch: expected %h, actual %h", want.hit_end, out_data.hit_end);
          mismatch_count++;
        end
        if (out_data.hit_offset !== want.hit_offset) begin
          $error("hit_offset mismatch: expected %h, actual %h",
                 want.hit_offset, out_data.hit_offset);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    foreach (tbl_valid[i]) begin
      tbl_valid[i] = 1'b0;
      tbl_start[i] = '0;
      tbl_end[i]   = '0;
      tbl_tag[i]   = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_duplicate();
    test_shadowing();
    test_address_extremes();
    test_random_traffic(1330);

    in_valid <= 1'b0;
    while (range_results_pending.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
